// ===== hw/rtl/stmv_pkg.sv =====
`timescale 1ns / 1ps

package stmv_pkg;

	localparam int COORD_BITS = 16;
	localparam int NORM_BITS  = 16;

	// vertex minus centroid
	localparam int DIFF_W  = COORD_BITS + 1;
	// v0 + v1 + v2 - 3c
	localparam int SUM_W   = COORD_BITS + 3;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int TPROD_W = DIFF_W + CROSS_W;
	localparam int TRIP_W  = TPROD_W + 2;
	localparam int DPROD_W = NORM_BITS + SUM_W;
	localparam int DOT_W   = DPROD_W + 2;

	localparam int VOL_W    = 52;
	localparam int ORIENT_W = 2;
	localparam int TOTAL_W  = 64;
	localparam int COUNT_W  = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = COORD_BITS;

	localparam int IN_W      = 9 * COORD_BITS + 3 * NORM_BITS;
	localparam int IN_BYTES  = (IN_W + 7) / 8;
	localparam int IN_TW     = 8 * IN_BYTES;
	localparam int OUT_W     = VOL_W + ORIENT_W + TOTAL_W + COUNT_W;
	localparam int OUT_BYTES = (OUT_W + 7) / 8;
	localparam int OUT_TW    = 8 * OUT_BYTES;

	localparam int STEP_W = 2;

	typedef enum logic [ORIENT_W-1:0] {
		ORIENT_NONE = 2'd0,
		ORIENT_ADD  = 2'd1,
		ORIENT_SUB  = 2'd2
	} orient_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTROID_X = 2'd0,
		REG_CENTROID_Y = 2'd1,
		REG_CENTROID_Z = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_MAG,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic              capture;
		logic              calc;
		logic [STEP_W-1:0] step;
		logic              mag;
		logic              commit;
	} dp_cmd_t;

endpackage

// ===== hw/rtl/stmv_ctrl.sv =====
`timescale 1ns / 1ps

module stmv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output stmv_pkg::dp_cmd_t  cmd
);

	stmv_pkg::state_t              state_q, state_d;
	logic [stmv_pkg::STEP_W-1:0]   step_q, step_d;
	logic                          out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stmv_pkg::ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		cmd         = '0;
		cmd.step    = step_q;
		s_axis_tready = 1'b0;
		case (state_q)
			stmv_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.capture = 1'b1;
					step_d      = '0;
					state_d     = stmv_pkg::ST_CALC;
				end
			end
			stmv_pkg::ST_CALC: begin
				cmd.calc = 1'b1;
				step_d   = step_q + 1'b1;
				if (step_q == '1) begin
					state_d = stmv_pkg::ST_MAG;
				end
			end
			stmv_pkg::ST_MAG: begin
				cmd.mag = 1'b1;
				state_d = stmv_pkg::ST_WRITE;
			end
			stmv_pkg::ST_WRITE: begin
				// wait for the output register to free up
				if (!out_valid_q || m_axis_tready) begin
					cmd.commit = 1'b1;
					state_d    = stmv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stmv_pkg::ST_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;

endmodule

// ===== hw/rtl/stmv_datapath.sv =====
`timescale 1ns / 1ps

module stmv_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  stmv_pkg::dp_cmd_t                   cmd,
	input  logic [stmv_pkg::IN_TW-1:0]          in_data,
	input  logic                                cfg_we,
	input  logic [stmv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [stmv_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [stmv_pkg::OUT_TW-1:0]         out_data
);

	localparam int CW  = stmv_pkg::COORD_BITS;
	localparam int NW  = stmv_pkg::NORM_BITS;
	localparam int DW  = stmv_pkg::DIFF_W;
	localparam int SW  = stmv_pkg::SUM_W;
	localparam int XW  = stmv_pkg::CROSS_W;
	localparam int TW  = stmv_pkg::TRIP_W;
	localparam int OW  = stmv_pkg::DOT_W;
	localparam int VW  = stmv_pkg::VOL_W;
	localparam int SUMW = stmv_pkg::TOTAL_W;
	localparam int CNW = stmv_pkg::COUNT_W;

	logic signed [CW-1:0] cen_q [3];

	// captured operands
	logic signed [DW-1:0] a_q [3];
	logic signed [DW-1:0] b_q [3];
	logic signed [DW-1:0] d_q [3];
	logic signed [SW-1:0] t_q [3];
	logic signed [NW-1:0] n_q [3];

	logic signed [DW-1:0] a_d [3];
	logic signed [DW-1:0] b_d [3];
	logic signed [DW-1:0] d_d [3];
	logic signed [SW-1:0] t_d [3];
	logic signed [NW-1:0] n_d [3];

	logic signed [XW-1:0] cross_q;
	logic signed [TW-1:0] trip_q;
	logic signed [OW-1:0] dot_q;

	logic [VW-1:0]        mag_q;
	stmv_pkg::orient_t    orient_q;

	logic signed [SUMW-1:0] total_q;
	logic [CNW-1:0]         count_q;
	logic [VW-1:0]          out_mag_q;
	stmv_pkg::orient_t      out_orient_q;

	// operand capture: differences to the centroid and the summed offset
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [CW-1:0] p0, p1, p2;
			logic signed [SW-1:0] c3;
			p0 = in_data[CW*k +: CW];
			p1 = in_data[CW*(3+k) +: CW];
			p2 = in_data[CW*(6+k) +: CW];
			n_d[k] = in_data[9*CW + NW*k +: NW];
			a_d[k] = DW'(p0) - DW'(cen_q[k]);
			b_d[k] = DW'(p1) - DW'(cen_q[k]);
			d_d[k] = DW'(p2) - DW'(cen_q[k]);
			c3     = (SW'(cen_q[k]) <<< 1) + SW'(cen_q[k]);
			t_d[k] = SW'(p0) + SW'(p1) + SW'(p2) - c3;
		end
	end

	// shared multipliers: step k forms cross component k and dot term k,
	// and folds the previous cross component into the triple product
	logic signed [DW-1:0]                 ma0, mb0, ma1, mb1, ta;
	logic signed [NW-1:0]                 dn;
	logic signed [SW-1:0]                 dt;
	logic signed [stmv_pkg::PROD_W-1:0]   pr0, pr1;
	logic signed [stmv_pkg::TPROD_W-1:0]  tprod;
	logic signed [stmv_pkg::DPROD_W-1:0]  dprod;

	always_comb begin
		ma0 = '0;
		mb0 = '0;
		ma1 = '0;
		mb1 = '0;
		ta  = '0;
		dn  = '0;
		dt  = '0;
		case (cmd.step)
			2'd0: begin
				ma0 = b_q[1]; mb0 = d_q[2]; ma1 = b_q[2]; mb1 = d_q[1];
				dn  = n_q[0]; dt  = t_q[0];
			end
			2'd1: begin
				ma0 = b_q[2]; mb0 = d_q[0]; ma1 = b_q[0]; mb1 = d_q[2];
				dn  = n_q[1]; dt  = t_q[1];
				ta  = a_q[0];
			end
			2'd2: begin
				ma0 = b_q[0]; mb0 = d_q[1]; ma1 = b_q[1]; mb1 = d_q[0];
				dn  = n_q[2]; dt  = t_q[2];
				ta  = a_q[1];
			end
			default: begin
				ta = a_q[2];
			end
		endcase
	end

	assign pr0   = ma0 * mb0;
	assign pr1   = ma1 * mb1;
	assign tprod = ta * cross_q;
	assign dprod = dn * dt;

	logic [TW-1:0] trip_abs;
	assign trip_abs = trip_q[TW-1] ? TW'(-trip_q) : TW'(trip_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			for (int k = 0; k < 3; k++) begin
				a_q[k] <= a_d[k];
				b_q[k] <= b_d[k];
				d_q[k] <= d_d[k];
				t_q[k] <= t_d[k];
				n_q[k] <= n_d[k];
			end
			cross_q <= '0;
			trip_q  <= '0;
			dot_q   <= '0;
		end else if (cmd.calc) begin
			cross_q <= XW'(pr0) - XW'(pr1);
			trip_q  <= trip_q + TW'(tprod);
			dot_q   <= dot_q + OW'(dprod);
		end
		if (cmd.mag) begin
			mag_q <= trip_abs[VW-1:0];
			if (dot_q == '0) begin
				orient_q <= stmv_pkg::ORIENT_NONE;
			end else if (dot_q[OW-1]) begin
				orient_q <= stmv_pkg::ORIENT_SUB;
			end else begin
				orient_q <= stmv_pkg::ORIENT_ADD;
			end
		end
		if (cmd.commit) begin
			out_mag_q    <= mag_q;
			out_orient_q <= orient_q;
		end
	end

	// saturating total, one extra bit to catch overflow
	logic signed [SUMW:0] acc_add, acc_sub;
	logic                 cnt_full;

	assign acc_add  = (SUMW+1)'(total_q) + $signed({1'b0, {(SUMW-VW){1'b0}}, mag_q});
	assign acc_sub  = (SUMW+1)'(total_q) - $signed({1'b0, {(SUMW-VW){1'b0}}, mag_q});
	assign cnt_full = &count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				cen_q[k] <= '0;
			end
			total_q <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				stmv_pkg::REG_CENTROID_X: begin
					cen_q[0] <= cfg_data;
					total_q  <= '0;
					count_q  <= '0;
				end
				stmv_pkg::REG_CENTROID_Y: begin
					cen_q[1] <= cfg_data;
					total_q  <= '0;
					count_q  <= '0;
				end
				stmv_pkg::REG_CENTROID_Z: begin
					cen_q[2] <= cfg_data;
					total_q  <= '0;
					count_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.commit) begin
			if (orient_q == stmv_pkg::ORIENT_ADD) begin
				if (acc_add[SUMW] != acc_add[SUMW-1]) begin
					total_q <= {1'b0, {(SUMW-1){1'b1}}};
				end else begin
					total_q <= acc_add[SUMW-1:0];
				end
			end else if (orient_q == stmv_pkg::ORIENT_SUB) begin
				if (acc_sub[SUMW] != acc_sub[SUMW-1]) begin
					total_q <= {1'b1, {(SUMW-1){1'b0}}};
				end else begin
					total_q <= acc_sub[SUMW-1:0];
				end
			end
			if (!cnt_full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	assign out_data = {{(stmv_pkg::OUT_TW-stmv_pkg::OUT_W){1'b0}},
		count_q, total_q, out_orient_q, out_mag_q};

endmodule

// ===== hw/rtl/signed_tetra_mesh_volume_top.sv =====
`timescale 1ns / 1ps

// Signed tetrahedron volume accumulator for a triangle mesh.
// Slave stream: one triangle per transaction; tdata holds first_x/y/z,
// second_x/y/z, third_x/y/z (Q7.8) and normal_x/y/z (Q1.14), 16 bits each.
// Master stream: one result per triangle with six_volume, orientation,
// the saturating running total and the triangle count after it.
// Centroid registers 0..2 are written through cfg_we/cfg_index/cfg_data;
// any such write clears the total and the count. Write only while idle.
// An item passes through a capture, four steps through the shared
// multiplier set (cross components, dot terms and triple product terms),
// the magnitude and sign, and the update of the total.
// The result sits in an output register; the next triangle is taken and
// worked on while it waits, and only the final update stalls until the
// receiver takes the pending result.
// Reset clears the centroid, the total, the count and all handshakes.
module signed_tetra_mesh_volume_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// first_x, first_y, first_z, second_x..z, third_x..z, normal_x..z
	input  logic [stmv_pkg::IN_TW-1:0]           s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// six_volume, orientation, total_six_volume, triangles_seen, zero pad
	output logic [stmv_pkg::OUT_TW-1:0]          m_axis_tdata,
	input  logic                                 cfg_we,
	input  logic [stmv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [stmv_pkg::CFG_DATA_W-1:0]      cfg_data
);

	stmv_pkg::dp_cmd_t cmd;

	stmv_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cmd           (cmd)
	);

	stmv_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_axis_tdata)
	);

endmodule
